[design/assert_macros.svh]
// Assertion helper macros for the key/value table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Assert an implication that is checked in the cycle after the condition.
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/chkv_pkg.sv]
// ----------------------------------------------------------------------------
// chkv_pkg
// Types and constants shared by the chained hash key/value table.
// ----------------------------------------------------------------------------
`default_nettype none
package chkv_pkg;

   localparam int Buckets = 1021;
   localparam int Pool = 1024;
   localparam int BW = $clog2(Buckets);
   localparam int LW = $clog2(Pool + 1);
   localparam int NW = $clog2(Pool);
   localparam logic [LW-1:0] NullLink = LW'(Pool);
   localparam logic [LW-1:0] PoolLim = LW'(Pool);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DUP      = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_HASH, S_FOLD, S_BKT, S_HREAD, S_HEAD, S_NREAD, S_NODE, S_ALLOC,
      S_AREAD, S_FREAD, S_DONE
   } state_type;

endpackage
`default_nettype wire

[design/chained_hash_key_value_table.sv]
// ----------------------------------------------------------------------------
// chained_hash_key_value_table
// Key/value table with an in-place head per bucket and pooled chain nodes.
// ----------------------------------------------------------------------------
// Usage:
//  A request (op, key, value) enters on req_valid/req_ready. One response
//  (status, found_value) leaves on rsp_valid/rsp_ready for every request.
//  Requests are worked one at a time. The bucket (31*key) mod 1021 is formed
//  in registered steps (multiply, fold, correct), the bucket memory read is
//  registered, and the chain walk reads pool nodes one at a time from the
//  node memory (read, then compare). An insert that appends a never-used
//  node passes through S_FREAD, one that takes a free-list node through
//  S_AREAD and then S_FREAD.
//  Reset clears the head valid bits and chain starts through a clearing pass
//  over all 1021 buckets of the bucket memory; no request is taken meanwhile.
//  The response sits in an output register; a stalled receiver holds it and
//  no request is taken until it is accepted. The next request can be taken
//  at the edge that accepts the response.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_key_value_table (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  chkv_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output chkv_pkg::rsp_type  rsp_data
);
   import chkv_pkg::*;

   // bucket memory: valid, key, data, chain start
   localparam int BMW = 1 + 32 + 32 + LW;
   localparam int NMW = 32 + 32 + LW;
   logic [BMW-1:0] bmem [Buckets];
   logic [NMW-1:0] nmem [Pool];

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [36:0] prod_ff;
   logic [BW+6:0] fold_ff, fold_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [BMW-1:0] brd_ff;
   logic [NMW-1:0] nrd_ff;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic [LW-1:0] free_ff, free_in, used_ff, used_in;
   logic [LW-1:0] newn_ff, newn_in;
   logic [BW-1:0] clr_ff;
   logic clearing_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_load;
   logic [31:0] pk_ff, pd_ff;

   logic b_we;  logic [BW-1:0] b_wa;  logic [BMW-1:0] b_wd;  logic [BW-1:0] b_ra;
   logic n_we;  logic [NW-1:0] n_wa;  logic [NMW-1:0] n_wd;  logic [NW-1:0] n_ra;
   logic n_we2; logic [NW-1:0] n_wa2; logic [NMW-1:0] n_wd2;

   logic         h_valid;
   logic [31:0]  h_key, h_data;
   logic [LW-1:0] h_chain;
   logic [31:0]  n_key, n_data;
   logic [LW-1:0] n_link;

   assign {h_valid, h_key, h_data, h_chain} = brd_ff;
   assign {n_key, n_data, n_link} = nrd_ff;

   assign req_ready = (state_ff == S_IDLE) && !clearing_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // fold 37-bit product: 2^10 mod 1021 = 3
   always_comb begin
      logic [BW+6:0] t;
      t = (BW+7)'(prod_ff[9:0]) + (BW+7)'(prod_ff[19:10]) * (BW+7)'(3)
          + (BW+7)'(prod_ff[29:20]) * (BW+7)'(9)
          + (BW+7)'(prod_ff[36:30]) * (BW+7)'(27);
      fold_in = t;
   end

   // final reduction of the folded value (at most 16728 on entry)
   always_comb begin
      logic [BW+6:0] r;
      r = fold_ff;
      // fold below 2^10 again, then correct
      r = (BW+7)'(r[9:0]) + (BW+7)'(r[BW+6:10]) * (BW+7)'(3);
      if (r >= (BW+7)'(Buckets)) r = r - (BW+7)'(Buckets);
      if (r >= (BW+7)'(Buckets)) r = r - (BW+7)'(Buckets);
      bkt_in = BW'(r);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff; prev_in = prev_ff; steps_in = steps_ff;
      free_in = free_ff; used_in = used_ff; newn_in = newn_ff;
      rsp_in = rsp_ff; rsp_load = 1'b0;
      b_we = 1'b0; b_wa = bkt_ff; b_wd = brd_ff; b_ra = bkt_ff;
      n_we = 1'b0; n_wa = NW'(cur_ff); n_wd = nrd_ff; n_ra = NW'(cur_ff);
      n_we2 = 1'b0; n_wa2 = NW'(prev_ff); n_wd2 = nrd_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) state_in = S_HASH;
         S_HASH: state_in = S_FOLD;
         S_FOLD: state_in = S_BKT;
         S_BKT: state_in = S_HREAD;
         S_HREAD: state_in = S_HEAD;
         S_HEAD: begin
            prev_in = NullLink; cur_in = h_chain; steps_in = '0;
            if (req_ff.op == OP_NONE) begin
               rsp_in = '{status: ST_NOTFOUND, found_value: '0};
               state_in = S_DONE;
            end else if (h_valid && h_key == req_ff.key) begin
               if (req_ff.op == OP_INSERT) begin
                  rsp_in = '{status: ST_DUP, found_value: '0};
               end else begin
                  rsp_in = '{status: ST_OK, found_value: h_data};
                  if (req_ff.op == OP_REMOVE) begin
                     b_we = 1'b1; b_wd = {1'b0, h_key, h_data, h_chain};
                  end
               end
               state_in = S_DONE;
            end else begin
               state_in = S_NREAD;
            end
         end
         S_NREAD: begin
            if (cur_ff < PoolLim && steps_ff < PoolLim) state_in = S_NODE;
            else state_in = S_ALLOC;
         end
         S_NODE: begin
            if (n_key == req_ff.key) begin
               if (req_ff.op == OP_INSERT) begin
                  rsp_in = '{status: ST_DUP, found_value: '0};
               end else begin
                  rsp_in = '{status: ST_OK, found_value: n_data};
                  if (req_ff.op == OP_REMOVE) begin
                     if (prev_ff == NullLink) begin
                        b_we = 1'b1; b_wd = {h_valid, h_key, h_data, n_link};
                     end else begin
                        // prev node's link: need its key/data -> kept in prev regs
                        n_we2 = 1'b1; n_wd2 = {pk_ff, pd_ff, n_link};
                     end
                     n_we = 1'b1; n_wd = {n_key, n_data, free_ff};
                     free_in = cur_ff;
                  end
               end
               state_in = S_DONE;
            end else begin
               prev_in = cur_ff; cur_in = n_link; steps_in = steps_ff + 1'b1;
               n_ra = NW'(n_link);
               state_in = S_NREAD;
            end
         end
         S_ALLOC: begin
            // chain end, no match
            if (req_ff.op != OP_INSERT) begin
               rsp_in = '{status: ST_NOTFOUND, found_value: '0};
               state_in = S_DONE;
            end else if (!h_valid) begin
               b_we = 1'b1; b_wd = {1'b1, req_ff.key, req_ff.value, h_chain};
               rsp_in = '{status: ST_OK, found_value: '0};
               state_in = S_DONE;
            end else if (free_ff < PoolLim) begin
               newn_in = free_ff; n_ra = NW'(free_ff);
               state_in = S_AREAD;
            end else if (used_ff < PoolLim) begin
               newn_in = used_ff; used_in = used_ff + 1'b1;
               state_in = S_FREAD;
            end else begin
               rsp_in = '{status: ST_FULL, found_value: '0};
               state_in = S_DONE;
            end
         end
         S_AREAD: begin
            // keep the free-list node on the read port
            n_ra = NW'(newn_ff);
            state_in = S_FREAD;
         end
         S_FREAD: begin
            if (newn_ff == free_ff) free_in = n_link;
            n_we = 1'b1; n_wa = NW'(newn_ff);
            n_wd = {req_ff.key, req_ff.value, NullLink};
            if (prev_ff == NullLink) begin
               b_we = 1'b1; b_wd = {h_valid, h_key, h_data, newn_ff};
            end else begin
               n_we2 = 1'b1; n_wd2 = {pk_ff, pd_ff, newn_ff};
            end
            rsp_in = '{status: ST_OK, found_value: '0};
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // remember key and data of the node ahead of the current one
   always_ff @(posedge clock) begin
      if (state_ff == S_NODE) begin
         pk_ff <= n_key;
         pd_ff <= n_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff <= NullLink;
         used_ff <= '0;
         clr_ff <= '0;
         clearing_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff <= free_in;
         used_ff <= used_in;
         if (clearing_ff) begin
            if (clr_ff == BW'(Buckets - 1)) clearing_ff <= 1'b0;
            clr_ff <= clr_ff + 1'b1;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers; the response builds up while the output is empty
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      prod_ff <= {5'd0, req_ff.key} * 37'd31;
      fold_ff <= fold_in;
      bkt_ff <= bkt_in;
      cur_ff <= cur_in; prev_ff <= prev_in; steps_ff <= steps_in;
      newn_ff <= newn_in;
      rsp_ff <= rsp_in;
   end

   // bucket memory, clearing pass after reset
   always_ff @(posedge clock) begin
      if (clearing_ff) bmem[clr_ff] <= {1'b0, 64'd0, NullLink};
      else if (b_we) bmem[b_wa] <= b_wd;
      brd_ff <= bmem[b_ra];
   end

   // node memory
   always_ff @(posedge clock) begin
      if (n_we) nmem[n_wa] <= n_wd;
      if (n_we2) nmem[n_wa2] <= n_wd2;
      nrd_ff <= nmem[n_ra];
   end

endmodule
`default_nettype wire

[design/chkv_checker.sv]
// ----------------------------------------------------------------------------
// chkv_checker
// Port-level checks for the chained hash key/value table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module chkv_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input chkv_pkg::req_type req_data,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input chkv_pkg::rsp_type rsp_data
);
   import chkv_pkg::*;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped while stalled")
   `CHK_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data), "request changed while waiting")
   `CHK_NEXT(a_one_busy, clock, reset, req_valid && req_ready, !req_ready, "second request taken while busy")
   `CHK_IMPLY(a_value_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.found_value == 32'd0, "value on failed response")
   `CHK_IMPLY(a_no_take_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken while response stalled")

endmodule

bind chained_hash_key_value_table chkv_checker u_chkv_checker (.*);
`default_nettype wire

[tb/table_checker.sv]
// ----------------------------------------------------------------------------
// table_checker
// Watches the request and response channels of the key/value table, keeps
// its own copy of the bucket heads, chains and node pool, and compares each
// response with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module table_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_ready,
   input  chkv_pkg::req_type req_data,
   input  wire               rsp_valid,
   input  wire               rsp_ready,
   input  chkv_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                rsp_count,
   output int                full_count
);
   import chkv_pkg::*;

   localparam int unsigned NoNode = Pool;

   bit          bkt_valid [Buckets];
   bit [31:0]   bkt_key [Buckets];
   bit [31:0]   bkt_data [Buckets];
   int unsigned bkt_chain [Buckets];
   bit [31:0]   pool_key [Pool];
   bit [31:0]   pool_data [Pool];
   int unsigned pool_next [Pool];
   int unsigned free_top;
   int unsigned fresh_next;
   rsp_type     pending_rsp [$];

   function automatic int unsigned bucket_index(bit [31:0] key);
      bit [36:0] prod;
      prod = 37'(key) * 37'd31;
      return int'(prod % 37'(Buckets));
   endfunction

   // Apply one request to the model state and return the predicted response.
   function automatic rsp_type apply_request(req_type rq);
      rsp_type     r;
      int unsigned b, cur, prev, hit, steps, n;
      bit          head_hit;
      r.status = ST_NOTFOUND;
      r.found_value = '0;
      b = bucket_index(rq.key);
      head_hit = bkt_valid[b] && bkt_key[b] == rq.key;
      prev = NoNode;
      hit = NoNode;
      if (rq.op != OP_NONE && !head_hit) begin
         cur = bkt_chain[b];
         steps = 0;
         while (cur < NoNode && steps < NoNode) begin
            if (pool_key[cur] == rq.key) begin
               hit = cur;
               break;
            end
            prev = cur;
            cur = pool_next[cur];
            steps++;
         end
      end
      case (rq.op)
         OP_INSERT: begin
            if (head_hit || hit != NoNode) begin
               r.status = ST_DUP;
            end else if (!bkt_valid[b]) begin
               bkt_valid[b] = 1;
               bkt_key[b] = rq.key;
               bkt_data[b] = rq.value;
               r.status = ST_OK;
            end else begin
               // take a freed node first, else the next never-used one
               n = NoNode;
               if (free_top < NoNode) begin
                  n = free_top;
                  free_top = pool_next[n];
               end else if (fresh_next < NoNode) begin
                  n = fresh_next;
                  fresh_next++;
               end
               if (n == NoNode) begin
                  r.status = ST_FULL;
               end else begin
                  pool_key[n] = rq.key;
                  pool_data[n] = rq.value;
                  pool_next[n] = NoNode;
                  if (prev == NoNode) bkt_chain[b] = n;
                  else pool_next[prev] = n;
                  r.status = ST_OK;
               end
            end
         end
         OP_REMOVE, OP_FIND: begin
            if (head_hit) begin
               r.found_value = bkt_data[b];
               if (rq.op == OP_REMOVE) bkt_valid[b] = 0;
               r.status = ST_OK;
            end else if (hit != NoNode) begin
               r.found_value = pool_data[hit];
               if (rq.op == OP_REMOVE) begin
                  if (prev == NoNode) bkt_chain[b] = pool_next[hit];
                  else pool_next[prev] = pool_next[hit];
                  pool_next[hit] = free_top;
                  free_top = hit;
               end
               r.status = ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Predict on each accepted request, compare on each accepted response.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < Buckets; i++) begin
            bkt_valid[i] = 0;
            bkt_chain[i] = NoNode;
         end
         free_top = NoNode;
         fresh_next = 0;
         pending_rsp.delete();
         fail_count <= 0;
         rsp_count <= 0;
         full_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (rsp_data.status == ST_FULL) full_count <= full_count + 1;
            if (pending_rsp.size() == 0) begin
               $display("%0t: response with none expected: status %0d value %h",
                  $time, rsp_data.status, rsp_data.found_value);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status
                     || rsp_data.found_value !== want.found_value) begin
                  $display("%0t: mismatch: expected status %0d value %h, got %0d %h",
                     $time, want.status, want.found_value,
                     rsp_data.status, rsp_data.found_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) pending_rsp.push_back(apply_request(req_data));
      end
      pending_count <= pending_rsp.size();
   end
endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives insert, remove and find requests into the key/value table: directed
// corner keys, colliding keys that build long chains, node removal and reuse
// off the free list, then random traffic with random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import chkv_pkg::*;

   logic    clock, reset;
   logic    req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending_count, rsp_count, full_count;
   int      sent_count;
   bit      long_hold;
   bit [31:0] key_pool [$];

   chained_hash_key_value_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   table_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .rsp_count(rsp_count), .full_count(full_count)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("TEST FAILED");
      $finish;
   end

   // Offer one request after a random gap and hold it until accepted.
   task automatic send_request(op_type op, bit [31:0] key, bit [31:0] value,
                               bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ((($urandom & 3) == 0) ? 0 : $urandom_range(0, 12));
      // drop valid only over a real gap, else offer the next request at once
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{op: op, key: key, value: value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Stop offering and wait until every expected response has come.
   task automatic drain_requests();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Keys 1021 apart share a bucket, since 31*1021 is a multiple of 1021.
   function automatic bit [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size()-1)];
      if (sel < 8) return 32'($urandom_range(0, 7)) + 32'd1021 * $urandom_range(0, 6);
      return $urandom;
   endfunction

   // Stall the response side at random, with one long hold when asked.
   initial begin
      int stall;
      rsp_ready <= 0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         stall = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 12);
         if (sent_count > 300 && sent_count < 420) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      bit [31:0] k;
      op_type    op;
      req_valid <= 0;
      req_data <= '0;
      sent_count = 0;
      long_hold = 0;
      reset <= 1;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed: key extremes, every op, op 3, duplicates, head reuse.
      send_request(OP_FIND, 32'h0, 32'h0);
      send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_INSERT, 32'h0, 32'h1234_5678);
      send_request(OP_INSERT, 32'd1021, 32'hAAAA_5555);
      send_request(OP_INSERT, 32'd2042, 32'h5555_AAAA);
      send_request(OP_INSERT, 32'd2042, 32'h1);
      send_request(OP_FIND, 32'd2042, 32'h0);
      send_request(OP_NONE, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'h0, 32'h0);
      send_request(OP_FIND, 32'h0, 32'h0);
      send_request(OP_FIND, 32'd1021, 32'h0);
      send_request(OP_INSERT, 32'd1021, 32'h7);
      send_request(OP_REMOVE, 32'd1021, 32'h0);
      send_request(OP_INSERT, 32'h0, 32'h9);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_INSERT, 32'd3063, 32'h3);

      // Build long chains: 540 keys over 12 buckets.
      // Receiver holds off early on so the block backs up.
      long_hold = 1;
      for (int i = 0; i < 540; i++) begin
         k = 32'd5000 + 32'(i % 12) + 32'd1021 * 32'(i / 12);
         send_request(OP_INSERT, k, $urandom, 1);
      end
      // Wait until the table has answered everything.
      drain_requests();

      // Free some nodes then reuse them off the free list.
      for (int i = 0; i < 60; i++) begin
         k = 32'd5000 + 32'(i % 12) + 32'd1021 * 32'($urandom_range(0, 50));
         send_request(($urandom & 1) ? OP_REMOVE : OP_FIND, k, 32'h0);
         key_pool.push_back(k);
      end

      // Random traffic, mostly on small colliding key sets.
      for (int i = 0; i < 280; i++) begin
         k = pick_key();
         case ($urandom_range(0, 19))
            0: op = OP_NONE;
            1, 2, 3, 4, 5, 6, 7: op = OP_INSERT;
            8, 9, 10, 11, 12, 13: op = OP_REMOVE;
            default: op = OP_FIND;
         endcase
         if (op == OP_INSERT && key_pool.size() < 64) key_pool.push_back(k);
         send_request(op, k, $urandom);
      end

      drain_requests();
      repeat (3000) @(posedge clock);
      $display("Covered corner keys, long colliding chains, node reuse and random ops.");
      $display("Sent %0d requests, checked %0d responses (%0d pool-full).",
         sent_count, rsp_count, full_count);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+design
design/chkv_pkg.sv
design/chained_hash_key_value_table.sv
design/chkv_checker.sv
tb/table_checker.sv
tb/testbench.sv
